// ===== rtl/pairwise_point_distance_top_defines.svh =====
// assertion macros shared by the pairwise distance rtl
`ifndef PAIRWISE_POINT_DISTANCE_TOP_DEFINES_SVH
`define PAIRWISE_POINT_DISTANCE_TOP_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define PPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pairwise distance check failed");

// next-cycle implication, checked on clk outside reset
`define PPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pairwise distance check failed");

`endif

// ===== rtl/ppd_pkg.sv =====
// shared types, constants and microcode for the pairwise distance block
package ppd_pkg;

  // default sizes of the point table
  localparam int DEF_MAX_POINTS   = 32;
  localparam int DEF_MAX_FEATURES = 16;

  // field widths
  localparam int PT_W    = 5;
  localparam int FI_W    = 4;
  localparam int FV_W    = 16;
  localparam int NF_W    = 5;
  localparam int DIST_W  = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // arithmetic widths: squares fit 32 bits, at most 31 of them summed
  localparam int SQ_W    = 32;
  localparam int SUM_W   = SQ_W + NF_W;
  localparam int RAD_W   = SUM_W + (SUM_W % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int NUM_W   = NF_W + 8;
  localparam int ITER_W  = 5;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // request and mode codes
  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam logic MODE_MISMATCH = 1'b0;
  localparam logic MODE_EUCLID   = 1'b1;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES = 1'b1;
  localparam logic              MODE_RESET = MODE_EUCLID;
  localparam logic [NF_W-1:0]   NF_RESET   = 5'd16;

  // request beat
  typedef struct packed {
    logic                   req_type;
    logic [PT_W-1:0]        point_a;
    logic [PT_W-1:0]        point_b;
    logic [FI_W-1:0]        feature_index;
    logic signed [FV_W-1:0] feature_value;
  } req_t;

  // response beat
  typedef struct packed {
    logic [PT_W-1:0]   pair_first;
    logic [PT_W-1:0]   pair_second;
    logic [DIST_W-1:0] distance;
  } rsp_t;

  // control from the sequencer into the iterative unit
  typedef struct packed {
    logic load_sqrt;
    logic load_div;
    logic step;
  } arith_ctrl_t;

  // microprogram addresses
  typedef enum logic [2:0] {
    U_IDLE      = 3'd0,
    U_WALK      = 3'd1,
    U_DRAIN     = 3'd2,
    U_SEL       = 3'd3,
    U_DIV_LOAD  = 3'd4,
    U_SQRT_LOAD = 3'd5,
    U_ITER      = 3'd6,
    U_FINISH    = 3'd7
  } step_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_WALK,
    OP_DIV_LOAD,
    OP_SQRT_LOAD,
    OP_STEP,
    OP_RESULT
  } uop_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NEVER,
    C_QUERY,
    C_LAST,
    C_PIPE_EMPTY,
    C_EUCLID,
    C_ITER_LAST,
    C_OUT_ROOM
  } cond_t;

  // one control word: on cond jump to target, else hold or fall through
  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
    logic  hold;
  } uword_t;

  // the microprogram
  function automatic uword_t ucode_rom(step_t addr);
    uword_t w;
    case (addr)
      U_IDLE:      w = '{op: OP_NONE,      cond: C_QUERY,      target: U_WALK,      hold: 1'b1};
      U_WALK:      w = '{op: OP_WALK,      cond: C_LAST,       target: U_DRAIN,     hold: 1'b1};
      U_DRAIN:     w = '{op: OP_NONE,      cond: C_PIPE_EMPTY, target: U_SEL,       hold: 1'b1};
      U_SEL:       w = '{op: OP_NONE,      cond: C_EUCLID,     target: U_SQRT_LOAD, hold: 1'b0};
      U_DIV_LOAD:  w = '{op: OP_DIV_LOAD,  cond: C_ALWAYS,     target: U_ITER,      hold: 1'b0};
      U_SQRT_LOAD: w = '{op: OP_SQRT_LOAD, cond: C_NEVER,      target: U_ITER,      hold: 1'b0};
      U_ITER:      w = '{op: OP_STEP,      cond: C_ITER_LAST,  target: U_FINISH,    hold: 1'b1};
      U_FINISH:    w = '{op: OP_RESULT,    cond: C_OUT_ROOM,   target: U_IDLE,      hold: 1'b1};
      default:     w = '{op: OP_NONE,      cond: C_ALWAYS,     target: U_IDLE,      hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ppd_arith.sv =====
// iterative square root and small divider, one result bit per cycle
module ppd_arith (
  input  logic                        clk,
  input  logic                        rst,
  input  ppd_pkg::arith_ctrl_t        ctrl,
  input  logic [ppd_pkg::SUM_W-1:0]   sum,
  input  logic [ppd_pkg::NF_W-1:0]    mism,
  input  logic [ppd_pkg::NF_W-1:0]    divisor,
  output logic                        iter_last,
  output logic [ppd_pkg::DIST_W-1:0]  result
);

  logic [ppd_pkg::RAD_W-1:0]  rad;
  logic [ppd_pkg::REM_W-1:0]  rem;
  logic [ppd_pkg::ROOT_W-1:0] root;
  logic [ppd_pkg::NF_W-1:0]   div_by;
  logic [ppd_pkg::ITER_W-1:0] cnt;
  logic                       sqrt_mode;

  logic [ppd_pkg::REM_W-1:0]  sq_sh;
  logic [ppd_pkg::REM_W-1:0]  sq_trial;
  logic [ppd_pkg::REM_W-1:0]  dv_sh;
  logic [ppd_pkg::REM_W-1:0]  dv_d;
  logic                       sq_ge;
  logic                       dv_ge;

  // trial subtract for one root digit or one quotient bit
  always_comb begin
    sq_sh    = {rem[ppd_pkg::REM_W-3:0], rad[ppd_pkg::RAD_W-1 -: 2]};
    sq_trial = ppd_pkg::REM_W'({root, 2'b01});
    sq_ge    = (sq_sh >= sq_trial);
    dv_sh    = {rem[ppd_pkg::REM_W-2:0], rad[ppd_pkg::RAD_W-1]};
    dv_d     = ppd_pkg::REM_W'(div_by);
    dv_ge    = (dv_sh >= dv_d);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load_sqrt) begin
      cnt <= ppd_pkg::ITER_W'(ppd_pkg::SQRT_STEPS);
    end else if (ctrl.load_div) begin
      cnt <= ppd_pkg::ITER_W'(ppd_pkg::DIV_STEPS);
    end else if (ctrl.step && cnt != '0) begin
      cnt <= cnt - ppd_pkg::ITER_W'(1);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load_sqrt) begin
      sqrt_mode <= 1'b1;
      rad       <= ppd_pkg::RAD_W'(sum);
      rem       <= '0;
      root      <= '0;
    end else if (ctrl.load_div) begin
      sqrt_mode <= 1'b0;
      rad       <= ppd_pkg::RAD_W'({mism, 8'h00}) << (ppd_pkg::RAD_W - ppd_pkg::NUM_W);
      rem       <= '0;
      root      <= '0;
      div_by    <= divisor;
    end else if (ctrl.step) begin
      if (sqrt_mode) begin
        rad  <= rad << 2;
        rem  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
        root <= {root[ppd_pkg::ROOT_W-2:0], sq_ge};
      end else begin
        rad  <= rad << 1;
        rem  <= dv_ge ? (dv_sh - dv_d) : dv_sh;
        root <= {root[ppd_pkg::ROOT_W-2:0], dv_ge};
      end
    end
  end

  assign iter_last = (cnt == ppd_pkg::ITER_W'(1));

  // saturate the root, quotient is always in range
  always_comb begin
    if (sqrt_mode && root > ppd_pkg::ROOT_W'(ppd_pkg::DIST_MAX)) begin
      result = ppd_pkg::DIST_MAX;
    end else begin
      result = root[ppd_pkg::DIST_W-1:0];
    end
  end

endmodule

// ===== rtl/pairwise_point_distance_top.sv =====
// pairwise point distance engine: point table, feature walk and microcoded control
// Request channel (req_valid / req_stall / req): a store beat writes one
// signed Q8.8 feature of one point; while the block is idle, stores are taken back to back.
// A query beat names two points; the block then gives one response beat
// (rsp_valid / rsp_stall / rsp) with both points and the distance in Q8.8.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) selects the
// metric and the feature count n; write it only while the block is idle.
// A query walks the table one feature per cycle through a dual read port,
// then runs an iterative unit: a square root in Euclidean mode, a division
// in mismatch mode. The next request beat can be taken in the same cycle
// in which the response becomes valid.
// Requests are stalled from query acceptance until the result is in the
// output register; a stalled response holds, and a finished query waits for
// room in the output register before the block goes idle again.
// Reset clears control and sets Euclidean mode with n = 16; the point table
// is not cleared and must be written before it is queried.
`include "pairwise_point_distance_top_defines.svh"

module pairwise_point_distance_top #(
  parameter int MAX_POINTS   = ppd_pkg::DEF_MAX_POINTS,
  parameter int MAX_FEATURES = ppd_pkg::DEF_MAX_FEATURES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  ppd_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output ppd_pkg::rsp_t                     rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_POINTS * MAX_FEATURES;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic                       metric_mode;
  logic [ppd_pkg::NF_W-1:0]   num_features;
  logic [ppd_pkg::NF_W-1:0]   eff_count;

  // sequencer
  ppd_pkg::step_t  upc;
  ppd_pkg::step_t  upc_next;
  ppd_pkg::uword_t uword;
  logic            cond_true;

  // query context
  logic [ppd_pkg::PT_W-1:0]   qa;
  logic [ppd_pkg::PT_W-1:0]   qb;
  logic [AW-1:0]              base_a;
  logic [AW-1:0]              base_b;
  logic [ppd_pkg::NF_W-1:0]   eff_n;
  logic [ppd_pkg::NF_W-1:0]   j;

  // table and walk pipeline
  logic [ppd_pkg::FV_W-1:0]   store_mem [DEPTH];
  logic [AW-1:0]              pt_base_lut [2**ppd_pkg::PT_W];
  logic [AW-1:0]              fi_lut [2**ppd_pkg::FI_W];
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr_a;
  logic [AW-1:0]              rd_addr_b;
  logic [ppd_pkg::FV_W-1:0]   rd_a;
  logic [ppd_pkg::FV_W-1:0]   rd_b;
  logic                       v1;
  logic                       v2;
  logic                       v3;
  logic signed [ppd_pkg::FV_W:0]     diff2;
  logic                              neq2;
  logic signed [2*ppd_pkg::FV_W+1:0] prod;
  logic [ppd_pkg::SQ_W-1:0]          sq3;
  logic                              neq3;
  logic [ppd_pkg::SUM_W-1:0]         acc;
  logic [ppd_pkg::NF_W-1:0]          mism;

  // handshakes
  logic                       req_take;
  logic                       store_we;
  logic                       query_take;
  logic                       out_room;
  logic                       out_load;

  // iterative unit
  ppd_pkg::arith_ctrl_t       actrl;
  logic                       iter_last;
  logic [ppd_pkg::DIST_W-1:0] arith_result;

  // wrap tables: point row base and feature offset
  for (genvar i = 0; i < 2**ppd_pkg::PT_W; i++) begin : g_pt_lut
    assign pt_base_lut[i] = AW'((i % MAX_POINTS) * MAX_FEATURES);
  end
  for (genvar i = 0; i < 2**ppd_pkg::FI_W; i++) begin : g_fi_lut
    assign fi_lut[i] = AW'(i % MAX_FEATURES);
  end

  // handshake decode
  assign req_stall  = (upc != ppd_pkg::U_IDLE);
  assign req_take   = req_valid && !req_stall;
  assign store_we   = req_take && (req.req_type == ppd_pkg::REQ_STORE);
  assign query_take = req_take && (req.req_type == ppd_pkg::REQ_QUERY);
  assign out_room   = !rsp_valid || !rsp_stall;
  assign cfg_ready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode  <= ppd_pkg::MODE_RESET;
      num_features <= ppd_pkg::NF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppd_pkg::CFG_METRIC_MODE:  metric_mode  <= cfg_data[0];
        ppd_pkg::CFG_NUM_FEATURES: num_features <= cfg_data[ppd_pkg::NF_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the feature count to 1 .. MAX_FEATURES
  always_comb begin
    if (num_features == '0) begin
      eff_count = ppd_pkg::NF_W'(1);
    end else if (int'(num_features) > MAX_FEATURES) begin
      eff_count = ppd_pkg::NF_W'(MAX_FEATURES);
    end else begin
      eff_count = num_features;
    end
  end

  // microcode fetch and jump condition
  always_comb begin
    uword = ppd_pkg::ucode_rom(upc);
    case (uword.cond)
      ppd_pkg::C_ALWAYS:     cond_true = 1'b1;
      ppd_pkg::C_NEVER:      cond_true = 1'b0;
      ppd_pkg::C_QUERY:      cond_true = query_take;
      ppd_pkg::C_LAST:       cond_true = (j == eff_n - ppd_pkg::NF_W'(1));
      ppd_pkg::C_PIPE_EMPTY: cond_true = !v1 && !v2 && !v3;
      ppd_pkg::C_EUCLID:     cond_true = (metric_mode == ppd_pkg::MODE_EUCLID);
      ppd_pkg::C_ITER_LAST:  cond_true = iter_last;
      ppd_pkg::C_OUT_ROOM:   cond_true = out_room;
      default:               cond_true = 1'b0;
    endcase
    if (cond_true) begin
      upc_next = uword.target;
    end else if (uword.hold) begin
      upc_next = upc;
    end else begin
      upc_next = ppd_pkg::step_t'(upc + 3'd1);
    end
  end

  // datapath strobes from the control word
  always_comb begin
    actrl.load_sqrt = (uword.op == ppd_pkg::OP_SQRT_LOAD);
    actrl.load_div  = (uword.op == ppd_pkg::OP_DIV_LOAD);
    actrl.step      = (uword.op == ppd_pkg::OP_STEP);
    out_load        = (uword.op == ppd_pkg::OP_RESULT) && out_room;
  end

  // microprogram counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ppd_pkg::U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // query context and feature counter
  always_ff @(posedge clk) begin
    if (query_take) begin
      qa     <= req.point_a;
      qb     <= req.point_b;
      base_a <= pt_base_lut[req.point_a];
      base_b <= pt_base_lut[req.point_b];
      eff_n  <= eff_count;
      j      <= '0;
    end else if (uword.op == ppd_pkg::OP_WALK) begin
      j <= j + ppd_pkg::NF_W'(1);
    end
  end

  // point table: one write port, two registered read ports
  assign wr_addr   = pt_base_lut[req.point_a] + fi_lut[req.feature_index];
  assign rd_addr_a = base_a + AW'(j);
  assign rd_addr_b = base_b + AW'(j);

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[wr_addr] <= req.feature_value;
    end
    rd_a <= store_mem[rd_addr_a];
    rd_b <= store_mem[rd_addr_b];
  end

  // walk pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= (uword.op == ppd_pkg::OP_WALK);
      v2 <= v1;
      v3 <= v2;
    end
  end

  // difference, square, accumulate
  assign prod = diff2 * diff2;

  always_ff @(posedge clk) begin
    diff2 <= $signed({rd_a[ppd_pkg::FV_W-1], rd_a}) - $signed({rd_b[ppd_pkg::FV_W-1], rd_b});
    neq2  <= (rd_a != rd_b);
    sq3   <= prod[ppd_pkg::SQ_W-1:0];
    neq3  <= neq2;
    if (query_take) begin
      acc  <= '0;
      mism <= '0;
    end else if (v3) begin
      acc  <= acc + ppd_pkg::SUM_W'(sq3);
      mism <= mism + ppd_pkg::NF_W'(neq3);
    end
  end

  // square root or mismatch fraction
  ppd_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (actrl),
    .sum       (acc),
    .mism      (mism),
    .divisor   (eff_n),
    .iter_last (iter_last),
    .result    (arith_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (out_load) begin
      rsp.pair_first  <= qa;
      rsp.pair_second <= qb;
      rsp.distance    <= arith_result;
    end
  end

  // checks on the sequencer and walk pipeline
  `PPD_ASSERT_NEXT(a_query_starts_walk, query_take, (upc == ppd_pkg::U_WALK) && (j == '0) && (acc == '0))
  `PPD_ASSERT_NOW(a_walk_in_range, upc == ppd_pkg::U_WALK, j < eff_n)
  `PPD_ASSERT_NOW(a_pipe_drained, upc == ppd_pkg::U_SEL, !v1 && !v2 && !v3)
  `PPD_ASSERT_NEXT(a_finish_shows_beat, (upc == ppd_pkg::U_FINISH) && out_room, rsp_valid && (upc == ppd_pkg::U_IDLE))

endmodule

// ===== tb/sv/tb_pairwise_point_distance_top.sv =====
// self-checking testbench for the pairwise point distance engine
`timescale 1ns / 100ps

module tb_pairwise_point_distance_top;

  localparam int NUM_POINTS = ppd_pkg::DEF_MAX_POINTS;
  localparam int NUM_FEATS  = ppd_pkg::DEF_MAX_FEATURES;
  localparam int GAP_MAX    = 17;
  localparam int SETTLE_CYC = 60;
  localparam int HOLD_CYC   = 400;
  localparam int HOLD_AT_1  = 100;
  localparam int HOLD_AT_2  = 300;
  localparam int PHASE_LEN  = 98;
  localparam int PRINT_CAP  = 100;

  // dut ports
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  ppd_pkg::req_t                  req       = '0;
  logic                           rsp_valid;
  logic                           rsp_stall = 1'b0;
  ppd_pkg::rsp_t                  rsp;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow of the point table and the registers, updated on accepted beats
  logic signed [ppd_pkg::FV_W-1:0] shadow_points [NUM_POINTS][NUM_FEATS];
  logic                            model_mode = ppd_pkg::MODE_RESET;
  logic [ppd_pkg::NF_W-1:0]        model_nf   = ppd_pkg::NF_RESET;

  // features already planned per point, so no query reads an unwritten entry
  logic [NUM_FEATS-1:0] planned_mask [NUM_POINTS] = '{default: '0};

  ppd_pkg::req_t queued_requests [$];
  ppd_pkg::rsp_t due_distances [$];

  logic calm = 1'b0;
  int   req_gap = 0;
  int   rsp_wait = 0;
  int   hold_left = 0;
  int   hold_count = 0;
  int   error_count = 0;
  int   store_count = 0;
  int   query_count = 0;
  int   results_seen = 0;
  int   config_count = 0;

  pairwise_point_distance_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // feature count after clamping zero up and large values down
  function automatic int used_features(logic [ppd_pkg::NF_W-1:0] nf);
    if (nf == 0) return 1;
    if (nf > NUM_FEATS) return NUM_FEATS;
    return nf;
  endfunction

  // expected distance between two points under the current registers
  function automatic logic [ppd_pkg::DIST_W-1:0] calc_distance(
      logic [ppd_pkg::PT_W-1:0] pa, logic [ppd_pkg::PT_W-1:0] pb);
    int n;
    int miss;
    longint a_val, b_val, diff;
    longint unsigned sum, root, trial;
    n = used_features(model_nf);
    miss = 0;
    sum = 0;
    for (int f = 0; f < n; f++) begin
      a_val = shadow_points[pa][f];
      b_val = shadow_points[pb][f];
      diff = a_val - b_val;
      sum += diff * diff;
      if (a_val != b_val) miss++;
    end
    if (model_mode == ppd_pkg::MODE_MISMATCH) return ppd_pkg::DIST_W'((miss * 256) / n);
    // floored square root, one result bit per pass
    root = 0;
    for (int b = ppd_pkg::DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum) root = trial;
    end
    return ppd_pkg::DIST_W'(root);
  endfunction

  // feature values: full range, a few small values that often repeat, or extremes
  function automatic logic [ppd_pkg::FV_W-1:0] draw_value(int style);
    case (style)
      0: return ppd_pkg::FV_W'($urandom);
      1: return ppd_pkg::FV_W'($urandom_range(0, 4)) - ppd_pkg::FV_W'(2);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  task automatic add_store(int pt, int feat, logic [ppd_pkg::FV_W-1:0] val);
    ppd_pkg::req_t r;
    r.req_type      = ppd_pkg::REQ_STORE;
    r.point_a       = ppd_pkg::PT_W'(pt);
    r.point_b       = ppd_pkg::PT_W'($urandom);
    r.feature_index = ppd_pkg::FI_W'(feat);
    r.feature_value = val;
    queued_requests.insert(queued_requests.size(), r);
    planned_mask[pt][feat] = 1'b1;
  endtask

  task automatic add_query(int pa, int pb);
    ppd_pkg::req_t r;
    r.req_type      = ppd_pkg::REQ_QUERY;
    r.point_a       = ppd_pkg::PT_W'(pa);
    r.point_b       = ppd_pkg::PT_W'(pb);
    r.feature_index = ppd_pkg::FI_W'($urandom);
    r.feature_value = ppd_pkg::FV_W'($urandom);
    queued_requests.insert(queued_requests.size(), r);
  endtask

  // wait for every beat to drain and every response to arrive, then let the block settle
  task automatic settle();
    while (queued_requests.size() != 0 || req_valid || due_distances.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // both registers, back to back on the config channel
  task automatic write_config(logic mode, logic [ppd_pkg::NF_W-1:0] nf);
    cfg_valid <= 1'b1;
    cfg_index <= ppd_pkg::CFG_METRIC_MODE;
    cfg_data  <= (ppd_pkg::CFG_DATA_W'($urandom) & ~ppd_pkg::CFG_DATA_W'(1)) |
                 ppd_pkg::CFG_DATA_W'(mode);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_mode = mode;
    cfg_index <= ppd_pkg::CFG_NUM_FEATURES;
    cfg_data  <= nf;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_nf = nf;
    cfg_valid <= 1'b0;
    config_count++;
  endtask

  // random traffic: point fills, query bursts over filled points, stray stores
  task automatic random_phase(logic [ppd_pkg::NF_W-1:0] nf, int count);
    int made;
    int pick;
    int pt;
    int k;
    int style;
    int pa;
    int pb;
    int ok_points [$];
    logic [NUM_FEATS:0] need;
    made = 0;
    need = (17'd1 << used_features(nf)) - 17'd1;
    while (made < count) begin
      ok_points.delete();
      for (int p = 0; p < NUM_POINTS; p++)
        if ((planned_mask[p] & need[NUM_FEATS-1:0]) == need[NUM_FEATS-1:0])
          ok_points.insert(ok_points.size(), p);
      pick = $urandom_range(0, 9);
      if (ok_points.size() < 2 || pick < 2) begin
        // fill one point, sometimes only its leading features
        pt = $urandom_range(0, NUM_POINTS - 1);
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NUM_FEATS) : NUM_FEATS;
        style = $urandom_range(0, 4);
        for (int f = 0; f < k; f++) add_store(pt, f, draw_value(style % 3));
        made += k;
      end else if (pick < 8) begin
        // burst of queries, now and then a point against itself
        repeat ($urandom_range(1, 6)) begin
          pa = ok_points[$urandom_range(0, ok_points.size() - 1)];
          pb = ($urandom_range(0, 7) == 0) ? pa
                                           : ok_points[$urandom_range(0, ok_points.size() - 1)];
          add_query(pa, pb);
          made++;
        end
      end else begin
        add_store($urandom_range(0, NUM_POINTS - 1), $urandom_range(0, NUM_FEATS - 1),
                  draw_value($urandom_range(0, 2)));
        made++;
      end
    end
  endtask

  // request driver: pops pending beats, idles a drawn number of cycles between them
  always @(posedge clk) begin : req_side
    ppd_pkg::rsp_t due;
    if (rst) begin
      req_valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_valid && !req_stall) begin
        if (req.req_type == ppd_pkg::REQ_STORE) begin
          shadow_points[req.point_a][req.feature_index] = req.feature_value;
          store_count++;
        end else begin
          due.pair_first  = req.point_a;
          due.pair_second = req.point_b;
          due.distance    = calc_distance(req.point_a, req.point_b);
          due_distances.insert(due_distances.size(), due);
          query_count++;
        end
      end
      if (!req_valid || !req_stall) begin
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          req <= queued_requests.pop_front();
          req_valid <= 1'b1;
          req_gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= PRINT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // long receiver hold-offs so the block backs up into its request side
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_count <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if ((hold_count == 0 && results_seen >= HOLD_AT_1) ||
                 (hold_count == 1 && results_seen >= HOLD_AT_2)) begin
      hold_left  <= HOLD_CYC;
      hold_count <= hold_count + 1;
    end
  end

  // response monitor: checks each beat against the oldest expectation and draws its stall
  always @(posedge clk) begin : rsp_side
    ppd_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_wait = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_distances.size() == 0) begin
          error_count++;
          if (error_count <= PRINT_CAP)
            $error("response for pair %0d,%0d with no query outstanding",
                   rsp.pair_first, rsp.pair_second);
        end else begin
          want = due_distances.pop_front();
          check_field("pair_first", want.pair_first, rsp.pair_first);
          check_field("pair_second", want.pair_second, rsp.pair_second);
          check_field("distance", want.distance, rsp.distance);
        end
        results_seen++;
        rsp_wait = calm ? 0 : $urandom_range(0, GAP_MAX);
      end else if (rsp_valid && rsp_wait > 0) begin
        rsp_wait--;
      end
      rsp_stall <= (rsp_wait > 0) || (hold_left > 0);
    end
  end

  // stimulus sequence
  initial begin
    logic [ppd_pkg::NF_W-1:0] nf_pick;
    logic                     mode_pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, equal points and half mismatch on two features
    add_store(0, 0, 16'h7fff);
    add_store(0, 1, 16'h8000);
    add_store(31, 0, 16'h8000);
    add_store(31, 1, 16'h7fff);
    add_store(1, 0, 16'h0000);
    add_store(1, 1, 16'h0000);
    add_store(2, 0, 16'h0100);
    add_store(2, 1, 16'h0080);
    add_store(3, 0, 16'h0000);
    add_store(3, 1, 16'h0005);
    add_store(5, 15, 16'hffff);
    settle();
    write_config(ppd_pkg::MODE_EUCLID, 5'd2);
    add_query(0, 31);
    add_query(31, 0);
    add_query(0, 0);
    add_query(0, 1);
    add_query(2, 1);
    settle();
    write_config(ppd_pkg::MODE_MISMATCH, 5'd2);
    add_query(0, 31);
    add_query(1, 1);
    add_query(3, 1);
    add_query(1, 0);
    settle();
    // zero feature count behaves as one
    write_config(ppd_pkg::MODE_MISMATCH, 5'd0);
    add_query(3, 1);
    add_query(0, 1);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      case (ph)
        0, 1: nf_pick = 5'd16;
        2:    nf_pick = 5'd1;
        3, 8: nf_pick = 5'd0;
        4, 9: nf_pick = 5'd31;
        5:    nf_pick = 5'd17;
        default: nf_pick = ppd_pkg::NF_W'($urandom_range(1, NUM_FEATS));
      endcase
      mode_pick = (ph % 2 == 0) ? ppd_pkg::MODE_EUCLID : ppd_pkg::MODE_MISMATCH;
      calm <= (ph % 4 == 2);
      write_config(mode_pick, nf_pick);
      random_phase(nf_pick, PHASE_LEN);
    end
    settle();

    $display("run covered %0d store beats and %0d distance queries over %0d register settings",
             store_count, query_count, config_count);
    $display("%0d responses checked, with %0d long receiver hold-offs",
             results_seen, hold_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout: %0d responses still due", due_distances.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== pairwise_point_distance_top.f =====
+incdir+rtl
rtl/ppd_pkg.sv
rtl/ppd_arith.sv
rtl/pairwise_point_distance_top.sv
tb/sv/tb_pairwise_point_distance_top.sv
